// ----- rtl/wecfm_pkg.sv -----
package wecfm_pkg;

	typedef enum logic [1:0] {
		FN_MOD_REPORT  = 2'd0,
		FN_COMP_REPORT = 2'd1,
		FN_READ        = 2'd2,
		FN_UNUSED      = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ACT_NONE       = 2'd0,
		ACT_BOARD_RST  = 2'd1,
		ACT_BOARD_PWR  = 2'd2,
		ACT_XCVR_PWR   = 2'd3
	} action_t;

	// component action map codes
	localparam logic [1:0] MAP_BOARD_PWR = 2'd1;
	localparam logic [1:0] MAP_XCVR_PWR  = 2'd2;

	localparam logic [2:0] REG_MOD_WINDOW  = 3'd0;
	localparam logic [2:0] REG_COMP_WINDOW = 3'd1;
	localparam logic [2:0] REG_MOD_THRESH  = 3'd2;
	localparam logic [2:0] REG_COMP_THRESH = 3'd3;
	localparam logic [2:0] REG_EXEMPT      = 3'd4;
	localparam logic [2:0] REG_ACTION_MAP  = 3'd5;

	localparam int unsigned PADDR_W = 6;
	localparam int unsigned PDATA_W = 64;

	localparam logic [31:0] MOD_WINDOW_RST  = 32'd300000;
	localparam logic [31:0] COMP_WINDOW_RST = 32'd1800000;
	localparam logic [7:0]  MOD_THRESH_RST  = 8'd10;
	localparam logic [7:0]  COMP_THRESH_RST = 8'd2;

	typedef struct packed {
		logic [31:0] mod_window;
		logic [31:0] comp_window;
		logic [7:0]  mod_thresh;
		logic [7:0]  comp_thresh;
		logic [3:0]  exempt_id;
		logic [63:0] action_map;
	} cfg_t;

	typedef struct packed {
		logic               send_report;
		logic               report_is_component;
		logic [4:0]         report_source;
		logic signed [31:0] report_code;
		logic [7:0]         new_count;
		logic [1:0]         action;
		logic [7:0]         module_count_out;
		logic [7:0]         component_count_out;
		logic               id_error;
	} result_t;

	typedef struct packed {
		logic load_in;
		logic commit;
	} ctrl_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CALC = 2'b10
	} state_t;

endpackage

// ----- rtl/wecfm_intf.sv -----
interface wecfm_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [4:0]         source_id;
	logic signed [31:0] error_code;
	logic [31:0]        now_ticks;

	modport source (output valid, func, source_id, error_code, now_ticks, input ready);
	modport sink (input valid, func, source_id, error_code, now_ticks, output ready);
endinterface

interface wecfm_rsp_if;
	logic               valid;
	logic               ready;
	logic               send_report;
	logic               report_is_component;
	logic [4:0]         report_source;
	logic signed [31:0] report_code;
	logic [7:0]         new_count;
	logic [1:0]         action;
	logic [7:0]         module_count_out;
	logic [7:0]         component_count_out;
	logic               id_error;

	modport source (output valid, send_report, report_is_component, report_source,
		report_code, new_count, action, module_count_out, component_count_out,
		id_error, input ready);
	modport sink (input valid, send_report, report_is_component, report_source,
		report_code, new_count, action, module_count_out, component_count_out,
		id_error, output ready);
endinterface

// ----- rtl/wecfm_cfg.sv -----
module wecfm_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wecfm_pkg::PADDR_W-1:0]     paddr,
	input  logic [wecfm_pkg::PDATA_W-1:0]     pwdata,
	output logic [wecfm_pkg::PDATA_W-1:0]     prdata,
	output wecfm_pkg::cfg_t                   cfg
);

	wecfm_pkg::cfg_t cfg_q;
	logic [2:0]      reg_idx;
	logic            wr_en;

	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mod_window  <= wecfm_pkg::MOD_WINDOW_RST;
			cfg_q.comp_window <= wecfm_pkg::COMP_WINDOW_RST;
			cfg_q.mod_thresh  <= wecfm_pkg::MOD_THRESH_RST;
			cfg_q.comp_thresh <= wecfm_pkg::COMP_THRESH_RST;
			cfg_q.exempt_id   <= '0;
			cfg_q.action_map  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				wecfm_pkg::REG_MOD_WINDOW:  cfg_q.mod_window  <= pwdata[31:0];
				wecfm_pkg::REG_COMP_WINDOW: cfg_q.comp_window <= pwdata[31:0];
				wecfm_pkg::REG_MOD_THRESH:  cfg_q.mod_thresh  <= pwdata[7:0];
				wecfm_pkg::REG_COMP_THRESH: cfg_q.comp_thresh <= pwdata[7:0];
				wecfm_pkg::REG_EXEMPT:      cfg_q.exempt_id   <= pwdata[3:0];
				wecfm_pkg::REG_ACTION_MAP:  cfg_q.action_map  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			wecfm_pkg::REG_MOD_WINDOW:  prdata = {32'd0, cfg_q.mod_window};
			wecfm_pkg::REG_COMP_WINDOW: prdata = {32'd0, cfg_q.comp_window};
			wecfm_pkg::REG_MOD_THRESH:  prdata = {56'd0, cfg_q.mod_thresh};
			wecfm_pkg::REG_COMP_THRESH: prdata = {56'd0, cfg_q.comp_thresh};
			wecfm_pkg::REG_EXEMPT:      prdata = {60'd0, cfg_q.exempt_id};
			wecfm_pkg::REG_ACTION_MAP:  prdata = cfg_q.action_map;
			default:                    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/wecfm_ctrl.sv -----
module wecfm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output wecfm_pkg::ctrl_cmd_t  cmd
);

	wecfm_pkg::state_t state_q, state_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free    = !out_valid_q || rsp_ready;
	assign req_ready   = (state_q == wecfm_pkg::ST_IDLE);
	assign cmd.load_in = req_valid && req_ready;
	// hold the request in CALC until the output register can take its result
	assign cmd.commit  = (state_q == wecfm_pkg::ST_CALC) && out_free;
	assign rsp_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wecfm_pkg::ST_IDLE: if (cmd.load_in) state_d = wecfm_pkg::ST_CALC;
			wecfm_pkg::ST_CALC: if (cmd.commit) state_d = wecfm_pkg::ST_IDLE;
			default:            state_d = wecfm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wecfm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/wecfm_dp.sv -----
module wecfm_dp #(
	parameter int MODULE_SOURCES    = 16,
	parameter int COMPONENT_SOURCES = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wecfm_pkg::ctrl_cmd_t  cmd,
	input  wecfm_pkg::cfg_t       cfg,
	input  logic [1:0]            func,
	input  logic [4:0]            source_id,
	input  logic signed [31:0]    error_code,
	input  logic [31:0]           now_ticks,
	output wecfm_pkg::result_t    result
);

	localparam int MIDX_W = (MODULE_SOURCES > 1) ? $clog2(MODULE_SOURCES) : 1;
	localparam int CIDX_W = (COMPONENT_SOURCES > 1) ? $clog2(COMPONENT_SOURCES) : 1;
	localparam logic [5:0] MOD_LIM  = 6'(MODULE_SOURCES);
	localparam logic [5:0] COMP_LIM = 6'(COMPONENT_SOURCES);

	logic [7:0]  mod_cnt_q   [MODULE_SOURCES];
	logic [31:0] mod_last_q  [MODULE_SOURCES];
	logic [7:0]  comp_cnt_q  [COMPONENT_SOURCES];
	logic [31:0] comp_last_q [COMPONENT_SOURCES];

	wecfm_pkg::func_t   func_s1;
	logic [4:0]         id_s1;
	logic signed [31:0] code_s1;
	logic [31:0]        now_s1;
	wecfm_pkg::result_t result_q;

	logic              m_ok, c_ok, is_comp;
	logic [MIDX_W-1:0] mi;
	logic [CIDX_W-1:0] ci;
	logic [7:0]        mcnt, ccnt, cur_cnt, base_cnt, inc_cnt, nxt_cnt, limit;
	logic [31:0]       cur_last, window, elapsed;
	logic              act;
	logic [1:0]        map_sel;
	logic              wr_mod, wr_comp;
	wecfm_pkg::result_t res_d;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_s1 <= wecfm_pkg::func_t'(func);
			id_s1   <= source_id;
			code_s1 <= error_code;
			now_s1  <= now_ticks;
		end
	end

	always_comb begin
		m_ok    = {1'b0, id_s1} < MOD_LIM;
		c_ok    = {1'b0, id_s1} < COMP_LIM;
		mi      = m_ok ? id_s1[MIDX_W-1:0] : '0;
		ci      = c_ok ? id_s1[CIDX_W-1:0] : '0;
		is_comp = (func_s1 == wecfm_pkg::FN_COMP_REPORT);
		mcnt    = mod_cnt_q[mi];
		ccnt    = comp_cnt_q[ci];
		cur_cnt  = is_comp ? ccnt : mcnt;
		cur_last = is_comp ? comp_last_q[ci] : mod_last_q[mi];
		window   = is_comp ? cfg.comp_window : cfg.mod_window;
		limit    = is_comp ? cfg.comp_thresh : cfg.mod_thresh;
		elapsed  = now_s1 - cur_last;
		// drop the count after a quiet window
		base_cnt = (elapsed > window) ? 8'd0 : cur_cnt;
		inc_cnt  = base_cnt + 8'd1;
		act      = inc_cnt > limit;
		nxt_cnt  = act ? 8'd0 : inc_cnt;
		map_sel  = cfg.action_map[{id_s1, 1'b0} +: 2];

		wr_mod  = cmd.commit && (func_s1 == wecfm_pkg::FN_MOD_REPORT) && m_ok;
		wr_comp = cmd.commit && is_comp && c_ok;

		res_d = '0;
		unique case (func_s1)
			wecfm_pkg::FN_MOD_REPORT: begin
				if (m_ok) begin
					res_d.send_report   = (id_s1 != {1'b0, cfg.exempt_id});
					res_d.report_source = id_s1;
					res_d.report_code   = code_s1;
					res_d.new_count     = nxt_cnt;
					res_d.action        = act ? wecfm_pkg::ACT_BOARD_RST : wecfm_pkg::ACT_NONE;
				end else begin
					res_d.id_error = 1'b1;
				end
			end
			wecfm_pkg::FN_COMP_REPORT: begin
				if (c_ok) begin
					res_d.send_report         = 1'b1;
					res_d.report_is_component = 1'b1;
					res_d.report_source       = id_s1;
					res_d.report_code         = code_s1;
					res_d.new_count           = nxt_cnt;
					if (act && (map_sel == wecfm_pkg::MAP_BOARD_PWR ||
						map_sel == wecfm_pkg::MAP_XCVR_PWR)) begin
						res_d.action = map_sel + 2'd1;
					end
				end else begin
					res_d.id_error = 1'b1;
				end
			end
			wecfm_pkg::FN_READ: begin
				res_d.module_count_out    = m_ok ? mcnt : 8'd0;
				res_d.component_count_out = c_ok ? ccnt : 8'd0;
				res_d.id_error            = !m_ok || !c_ok;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MODULE_SOURCES; i++) begin
				mod_cnt_q[i]  <= '0;
				mod_last_q[i] <= '0;
			end
			for (int i = 0; i < COMPONENT_SOURCES; i++) begin
				comp_cnt_q[i]  <= '0;
				comp_last_q[i] <= '0;
			end
		end else begin
			if (wr_mod) begin
				mod_cnt_q[mi]  <= nxt_cnt;
				mod_last_q[mi] <= now_s1;
			end
			if (wr_comp) begin
				comp_cnt_q[ci]  <= nxt_cnt;
				comp_last_q[ci] <= now_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q <= res_d;
		end
	end

	assign result = result_q;

endmodule

// ----- rtl/windowed_error_count_fault_manager.sv -----
// Error-count fault manager. Each request is first captured into input registers;
// then its source's count and last-error time, flip-flop tables cleared at once by
// reset, go through a read-modify-write. A new request is taken only once the
// previous one has gone to the output register; a finished
// result waits in the output register while the next request is captured, and
// the block stalls in its compute state only while that register is still full.
// Configuration sits on the APB port at 8-byte steps (64-bit data); the user must
// write it only while no request is in flight, which the block does not enforce.
module windowed_error_count_fault_manager #(
	parameter int MODULE_SOURCES    = 16,
	parameter int COMPONENT_SOURCES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	wecfm_req_if.sink                     req,
	wecfm_rsp_if.source                   rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wecfm_pkg::PADDR_W-1:0] paddr,
	input  logic [wecfm_pkg::PDATA_W-1:0] pwdata,
	output logic [wecfm_pkg::PDATA_W-1:0] prdata,
	output logic                          pready
);

	wecfm_pkg::cfg_t      cfg;
	wecfm_pkg::ctrl_cmd_t cmd;
	wecfm_pkg::result_t   result;
	logic                 req_ready;
	logic                 rsp_valid;

	assign pready = 1'b1;

	wecfm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	wecfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	wecfm_dp #(
		.MODULE_SOURCES    (MODULE_SOURCES),
		.COMPONENT_SOURCES (COMPONENT_SOURCES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.func       (req.func),
		.source_id  (req.source_id),
		.error_code (req.error_code),
		.now_ticks  (req.now_ticks),
		.result     (result)
	);

	assign req.ready               = req_ready;
	assign rsp.valid               = rsp_valid;
	assign rsp.send_report         = result.send_report;
	assign rsp.report_is_component = result.report_is_component;
	assign rsp.report_source       = result.report_source;
	assign rsp.report_code         = result.report_code;
	assign rsp.new_count           = result.new_count;
	assign rsp.action              = result.action;
	assign rsp.module_count_out    = result.module_count_out;
	assign rsp.component_count_out = result.component_count_out;
	assign rsp.id_error            = result.id_error;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous one still computing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !rsp.valid || rsp.ready)
		else $error("pending result overwritten");

	a_id_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.id_error |-> !rsp.send_report && rsp.new_count == 8'd0
			&& rsp.action == wecfm_pkg::ACT_NONE)
		else $error("bad id produced a report");

endmodule

// ----- sim/tb_windowed_error_count_fault_manager.sv -----
module tb_windowed_error_count_fault_manager;

	localparam int MOD_SRC  = 16;
	localparam int COMP_SRC = 32;

	typedef struct packed {
		wecfm_pkg::func_t   func;
		logic [4:0]         id;
		logic signed [31:0] code;
		logic [31:0]        now;
	} report_req_t;

	class fault_count_scoreboard;
		logic [31:0] mod_window;
		logic [31:0] comp_window;
		logic [7:0]  mod_thresh;
		logic [7:0]  comp_thresh;
		logic [3:0]  exempt_id;
		logic [63:0] action_map;

		logic [7:0]  mod_count [MOD_SRC];
		logic [31:0] mod_last [MOD_SRC];
		logic [7:0]  comp_count [COMP_SRC];
		logic [31:0] comp_last [COMP_SRC];

		wecfm_pkg::result_t expected_results[$];
		int unsigned        mismatches;
		int unsigned        checked;
		int unsigned        actions;
		int unsigned        id_errors;

		function new();
			mod_window  = wecfm_pkg::MOD_WINDOW_RST;
			comp_window = wecfm_pkg::COMP_WINDOW_RST;
			mod_thresh  = wecfm_pkg::MOD_THRESH_RST;
			comp_thresh = wecfm_pkg::COMP_THRESH_RST;
			exempt_id   = '0;
			action_map  = '0;
			foreach (mod_count[i]) begin
				mod_count[i] = '0;
				mod_last[i]  = '0;
			end
			foreach (comp_count[i]) begin
				comp_count[i] = '0;
				comp_last[i]  = '0;
			end
			mismatches = 0;
			checked    = 0;
			actions    = 0;
			id_errors  = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] value);
			case (idx)
				wecfm_pkg::REG_MOD_WINDOW:  mod_window  = value[31:0];
				wecfm_pkg::REG_COMP_WINDOW: comp_window = value[31:0];
				wecfm_pkg::REG_MOD_THRESH:  mod_thresh  = value[7:0];
				wecfm_pkg::REG_COMP_THRESH: comp_thresh = value[7:0];
				wecfm_pkg::REG_EXEMPT:      exempt_id   = value[3:0];
				wecfm_pkg::REG_ACTION_MAP:  action_map  = value;
				default: ;
			endcase
		endfunction

		// clear on a quiet window, count, then drop to zero once past the limit
		function logic [7:0] bump_count(logic [7:0] cnt, logic [31:0] elapsed,
				logic [31:0] window, logic [7:0] limit, output logic fire);
			if (elapsed > window)
				cnt = '0;
			cnt = cnt + 8'd1;
			fire = cnt > limit;
			return fire ? 8'd0 : cnt;
		endfunction

		function void note_request(report_req_t r);
			wecfm_pkg::result_t want;
			logic               fire;
			logic [1:0]         sel;
			logic [3:0]         mi;
			want = '0;
			mi   = r.id[3:0];
			case (r.func)
				wecfm_pkg::FN_MOD_REPORT: begin
					if (r.id >= MOD_SRC) begin
						want.id_error = 1'b1;
					end else begin
						mod_count[mi] = bump_count(mod_count[mi], r.now - mod_last[mi],
							mod_window, mod_thresh, fire);
						mod_last[mi] = r.now;
						want.send_report   = mi != exempt_id;
						want.report_source = r.id;
						want.report_code   = r.code;
						want.new_count     = mod_count[mi];
						want.action        = fire ? wecfm_pkg::ACT_BOARD_RST :
							wecfm_pkg::ACT_NONE;
					end
				end
				wecfm_pkg::FN_COMP_REPORT: begin
					if (r.id >= COMP_SRC) begin
						want.id_error = 1'b1;
					end else begin
						comp_count[r.id] = bump_count(comp_count[r.id], r.now - comp_last[r.id],
							comp_window, comp_thresh, fire);
						comp_last[r.id] = r.now;
						sel = action_map[2*r.id +: 2];
						want.send_report         = 1'b1;
						want.report_is_component = 1'b1;
						want.report_source       = r.id;
						want.report_code         = r.code;
						want.new_count           = comp_count[r.id];
						want.action = !fire ? wecfm_pkg::ACT_NONE :
							sel == wecfm_pkg::MAP_BOARD_PWR ? wecfm_pkg::ACT_BOARD_PWR :
							sel == wecfm_pkg::MAP_XCVR_PWR ? wecfm_pkg::ACT_XCVR_PWR :
							wecfm_pkg::ACT_NONE;
					end
				end
				wecfm_pkg::FN_READ: begin
					want.module_count_out    = r.id < MOD_SRC ? mod_count[mi] : 8'd0;
					want.component_count_out = r.id < COMP_SRC ? comp_count[r.id] : 8'd0;
					want.id_error            = r.id >= MOD_SRC || r.id >= COMP_SRC;
				end
				default: ;
			endcase
			expected_results.push_back(want);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(wecfm_pkg::result_t got);
			wecfm_pkg::result_t want;
			if (expected_results.size() == 0) begin
				$error("result %h with no request outstanding", got);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			checked++;
			if (want.action != wecfm_pkg::ACT_NONE)
				actions++;
			if (want.id_error)
				id_errors++;
			compare("send_report", 32'(want.send_report), 32'(got.send_report));
			compare("report_is_component", 32'(want.report_is_component),
				32'(got.report_is_component));
			compare("report_source", 32'(want.report_source), 32'(got.report_source));
			compare("report_code", want.report_code, got.report_code);
			compare("new_count", 32'(want.new_count), 32'(got.new_count));
			compare("action", 32'(want.action), 32'(got.action));
			compare("module_count_out", 32'(want.module_count_out),
				32'(got.module_count_out));
			compare("component_count_out", 32'(want.component_count_out),
				32'(got.component_count_out));
			compare("id_error", 32'(want.id_error), 32'(got.id_error));
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [wecfm_pkg::PADDR_W-1:0]   paddr;
	logic [wecfm_pkg::PDATA_W-1:0]   pwdata;
	logic [wecfm_pkg::PDATA_W-1:0]   prdata;
	logic                            pready;

	wecfm_req_if req();
	wecfm_rsp_if rsp();

	fault_count_scoreboard sb = new();

	logic               send_idle_on = 1'b1;
	logic               take_idle_on = 1'b1;
	logic [31:0]        ticks = '0;
	int unsigned        burst_left = 0;
	wecfm_pkg::func_t   burst_func = wecfm_pkg::FN_MOD_REPORT;
	logic [4:0]         burst_id = '0;
	int unsigned        settings = 0;

	windowed_error_count_fault_manager #(
		.MODULE_SOURCES(MOD_SRC),
		.COMPONENT_SOURCES(COMP_SRC)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin : watch_channels
		wecfm_pkg::result_t got;
		report_req_t        seen;
		// retire results before noting new requests so an unrequested result is caught
		if (rsp.valid && rsp.ready) begin
			got = {rsp.send_report, rsp.report_is_component, rsp.report_source,
				rsp.report_code, rsp.new_count, rsp.action, rsp.module_count_out,
				rsp.component_count_out, rsp.id_error};
			sb.check_result(got);
		end
		if (req.valid && req.ready) begin
			seen.func = wecfm_pkg::func_t'(req.func);
			seen.id   = req.source_id;
			seen.code = req.error_code;
			seen.now  = req.now_ticks;
			sb.note_request(seen);
		end
	end

	initial begin : take_results
		int unsigned stall;
		@(negedge clk);
		forever begin
			stall = take_idle_on ? $urandom_range(0, 14) : 0;
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		#8000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// entered and left at a falling edge
	task automatic send_request(input report_req_t r);
		int unsigned gap;
		gap = send_idle_on ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.func       <= r.func;
		req.source_id  <= r.id;
		req.error_code <= r.code;
		req.now_ticks  <= r.now;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic quiesce(input int unsigned extra);
		int unsigned waited;
		waited = 0;
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic program_registers(input logic [31:0] mw, input logic [31:0] cw,
			input logic [7:0] mt, input logic [7:0] ct, input logic [3:0] ex,
			input logic [63:0] amap);
		quiesce(4);
		write_reg(wecfm_pkg::REG_MOD_WINDOW, 64'(mw));
		write_reg(wecfm_pkg::REG_COMP_WINDOW, 64'(cw));
		write_reg(wecfm_pkg::REG_MOD_THRESH, 64'(mt));
		write_reg(wecfm_pkg::REG_COMP_THRESH, 64'(ct));
		write_reg(wecfm_pkg::REG_EXEMPT, 64'(ex));
		write_reg(wecfm_pkg::REG_ACTION_MAP, amap);
		settings++;
	endtask

	// bursts on one source drive its count toward the threshold; the rest is mixed traffic
	function automatic report_req_t random_request(int unsigned step_max);
		report_req_t r;
		int unsigned pick;
		r.code = $urandom;
		if (burst_left == 0 && $urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(2, 14);
			burst_func = $urandom_range(0, 1) ? wecfm_pkg::FN_COMP_REPORT :
				wecfm_pkg::FN_MOD_REPORT;
			burst_id   = burst_func == wecfm_pkg::FN_MOD_REPORT ?
				5'($urandom_range(0, MOD_SRC - 1)) : 5'($urandom_range(0, COMP_SRC - 1));
		end
		if (burst_left != 0) begin
			burst_left--;
			r.func = burst_func;
			r.id   = burst_id;
			ticks  = ticks + $urandom_range(0, step_max);
		end else begin
			pick = $urandom_range(0, 99);
			r.func = pick < 40 ? wecfm_pkg::FN_MOD_REPORT :
				pick < 80 ? wecfm_pkg::FN_COMP_REPORT :
				pick < 95 ? wecfm_pkg::FN_READ : wecfm_pkg::FN_UNUSED;
			r.id = $urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 31)) :
				5'($urandom_range(0, 5));
			if ($urandom_range(0, 19) == 0)
				ticks = $urandom;
			else
				ticks = ticks + $urandom_range(0, step_max);
		end
		r.now = ticks;
		return r;
	endfunction

	task automatic run_random_phase(input int unsigned count, input int unsigned step_max);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				send_idle_on = $urandom_range(0, 3) != 0;
				take_idle_on = $urandom_range(0, 3) != 0;
			end
			// hold the sender until the block has drained
			if (i == count / 2)
				quiesce(1);
			send_request(random_request(step_max));
		end
	endtask

	initial begin : stimulus
		logic [31:0] mw;
		logic [31:0] cw;
		report_req_t r;

		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.func       = wecfm_pkg::FN_MOD_REPORT;
		req.source_id  = '0;
		req.error_code = '0;
		req.now_ticks  = '0;
		rsp.ready      = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: exempt module 0, empty action map
		send_request('{wecfm_pkg::FN_MOD_REPORT, 5'd0, 32'sh80000000, 32'd0});
		send_request('{wecfm_pkg::FN_MOD_REPORT, 5'd15, 32'sh7fffffff, 32'hffffffff});
		send_request('{wecfm_pkg::FN_MOD_REPORT, 5'd16, -32'sd1, 32'd5});
		send_request('{wecfm_pkg::FN_MOD_REPORT, 5'd31, 32'sd0, 32'd6});
		// tick wrap keeps the count alive
		send_request('{wecfm_pkg::FN_COMP_REPORT, 5'd31, 32'sd0, 32'hfffffff0});
		send_request('{wecfm_pkg::FN_COMP_REPORT, 5'd31, -32'sd1, 32'h00000010});
		send_request('{wecfm_pkg::FN_COMP_REPORT, 5'd31, 32'sd77, 32'h00000020});
		// elapsed equal to the window keeps counting, one more tick clears
		send_request('{wecfm_pkg::FN_COMP_REPORT, 5'd0, 32'sd1, 32'd1000});
		send_request('{wecfm_pkg::FN_COMP_REPORT, 5'd0, 32'sd2, 32'd1801000});
		send_request('{wecfm_pkg::FN_COMP_REPORT, 5'd0, 32'sd3, 32'd3601001});
		send_request('{wecfm_pkg::FN_READ, 5'd15, 32'sd0, 32'd0});
		send_request('{wecfm_pkg::FN_READ, 5'd16, 32'sd0, 32'd0});
		send_request('{wecfm_pkg::FN_READ, 5'd31, 32'sd0, 32'd0});
		send_request('{wecfm_pkg::FN_READ, 5'd0, 32'sd0, 32'd0});
		send_request('{wecfm_pkg::FN_UNUSED, 5'd5, 32'sd123, 32'd77});
		// exempt module crosses its threshold
		for (int k = 0; k < 10; k++)
			send_request('{wecfm_pkg::FN_MOD_REPORT, 5'd0, 32'(k), 32'(100 + k)});

		program_registers(32'd0, 32'hffffffff, 8'd0, 8'd255, 4'd15, 64'hffff_ffff_ffff_ffff);
		run_random_phase(210, 2);
		program_registers(32'hffffffff, 32'd0, 8'd255, 8'd0, 4'd7, 64'h5555_5555_5555_5555);
		run_random_phase(210, 3);
		program_registers(wecfm_pkg::MOD_WINDOW_RST, wecfm_pkg::COMP_WINDOW_RST, 8'd1, 8'd1,
			4'd0, 64'haaaa_aaaa_aaaa_aaaa);
		run_random_phase(210, 40000);

		// module count wraps past 255 with no window clear
		program_registers(32'hffffffff, 32'hffffffff, 8'd255, 8'd255, 4'd3, 64'h0);
		send_idle_on = 1'($urandom_range(0, 1));
		take_idle_on = 1'($urandom_range(0, 1));
		for (int k = 0; k < 258; k++) begin
			r.func = wecfm_pkg::FN_MOD_REPORT;
			r.id   = 5'd9;
			r.code = $urandom;
			r.now  = $urandom;
			send_request(r);
		end

		for (int p = 0; p < 4; p++) begin
			mw = $urandom_range(0, 400);
			cw = $urandom_range(0, 400);
			program_registers(mw, cw,
				$urandom_range(0, 5) == 0 ? 8'd254 : 8'($urandom_range(1, 12)),
				$urandom_range(0, 5) == 0 ? 8'd254 : 8'($urandom_range(1, 6)),
				4'($urandom_range(0, 15)), {$urandom, $urandom});
			run_random_phase(210, (mw + cw) / 16 + 1);
		end

		quiesce(20);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.mismatches++;
		end
		$display("Checked %0d results across %0d register settings:", sb.checked, settings);
		$display("  %0d recovery actions, %0d out-of-range ids.", sb.actions, sb.id_errors);
		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/wecfm_pkg.sv
rtl/wecfm_intf.sv
rtl/wecfm_cfg.sv
rtl/wecfm_ctrl.sv
rtl/wecfm_dp.sv
rtl/windowed_error_count_fault_manager.sv
sim/tb_windowed_error_count_fault_manager.sv
